>>> rtl/tte_pkg.sv
// Shared types and constants of the tap tempo BPM estimator.
package tte_pkg;

    // Width of the timestamp, tempo and interval fields on the ports.
    localparam int DATA_W = 32;

    // Reset value of the ticks-per-minute register (microsecond ticks).
    localparam logic [DATA_W-1:0] TPM_RESET = 32'd60000000;

    // Number of commands the queue between front and back can hold.
    localparam int QUEUE_DEPTH = 2;

    // One input request.
    typedef struct packed {
        logic              channel;
        logic [DATA_W-1:0] stamp;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic              updated;
        logic [DATA_W-1:0] bpm;
        logic [DATA_W-1:0] beat_interval;
    } out_item_t;

    // What the front decided about a request.
    typedef enum logic [1:0] {
        CMD_IGNORE,
        CMD_REPEAT,
        CMD_NEW
    } cmd_kind_e;

    // Control part of a queued command.
    typedef struct packed {
        cmd_kind_e kind;
        logic      channel;
    } cmd_ctl_t;

    // Sequencer of the back part.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV3,
        ST_AVG,
        ST_DIVIDE,
        ST_RESULT
    } back_state_e;

endpackage

>>> rtl/tte_queue.sv
// Small command queue between the front and the back part.
module tte_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W = (tte_pkg::QUEUE_DEPTH > 1) ? $clog2(tte_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tte_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [tte_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(tte_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill count; a wrap happens at the queue depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                if (wr_ptr_reg == PTR_W'(tte_pkg::QUEUE_DEPTH - 1)) begin
                    wr_ptr_reg <= '0;
                end else begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (pop) begin
                if (rd_ptr_reg == PTR_W'(tte_pkg::QUEUE_DEPTH - 1)) begin
                    rd_ptr_reg <= '0;
                end else begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/tte_front.sv
// Front part: accepts requests, keeps the stamp history and forms the intervals.
module tte_front #(
    parameter int CHANNELS   = 2,
    parameter int TIME_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tte_pkg::in_item_t   s_data,
    input  logic                q_full,
    output logic                q_push,
    output logic [$bits(tte_pkg::cmd_ctl_t)+3*TIME_WIDTH-1:0] q_data
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIST     = 3;

    // Last three stamps of each channel, oldest first; the newest is the previous stamp.
    logic [TIME_WIDTH-1:0] hist_reg [CHANNELS][HIST];

    logic [TIME_WIDTH-1:0] stamp;
    logic [TIME_WIDTH-1:0] h0;
    logic [TIME_WIDTH-1:0] h1;
    logic [TIME_WIDTH-1:0] h2;
    logic [CH_IDX_W-1:0]   idx;
    logic                  ch_ok;
    tte_pkg::cmd_ctl_t     ctl;
    logic                  accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    assign stamp = TIME_WIDTH'(s_data.stamp);
    assign idx   = CH_IDX_W'(s_data.channel);
    assign ch_ok = (32'(s_data.channel) < 32'(CHANNELS));
    assign h0    = hist_reg[idx][0];
    assign h1    = hist_reg[idx][1];
    assign h2    = hist_reg[idx][2];

    // Classify the request: unknown channel, repeated stamp or a new beat.
    always_comb begin
        ctl.channel = s_data.channel;
        if (!ch_ok) begin
            ctl.kind = tte_pkg::CMD_IGNORE;
        end else if (stamp == h2) begin
            ctl.kind = tte_pkg::CMD_REPEAT;
        end else begin
            ctl.kind = tte_pkg::CMD_NEW;
        end
    end

    // Intervals oldest first, wrapping at the time width.
    assign q_data = {ctl, h1 - h0, h2 - h1, stamp - h2};

    // Shift the new stamp into the channel's history.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                for (int i = 0; i < HIST; i++) begin
                    hist_reg[ch][i] <= '0;
                end
            end
        end else if (accept && ctl.kind == tte_pkg::CMD_NEW) begin
            hist_reg[idx][0] <= h1;
            hist_reg[idx][1] <= h2;
            hist_reg[idx][2] <= stamp;
        end
    end

endmodule

>>> rtl/tte_div.sv
// Restoring divider, one quotient bit per cycle.
module tte_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign done  = done_reg;
    assign quo   = quo_reg;

    // Bring down the next numerator bit and try the subtraction.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    // Control of the iteration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient; the quotient shifts in where the numerator shifts out.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

endmodule

>>> rtl/tte_back.sv
// Back part: tempo check, average interval, BPM division and per-channel tempo storage.
module tte_back #(
    parameter int CHANNELS   = 2,
    parameter int TIME_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_not_empty,
    input  logic [$bits(tte_pkg::cmd_ctl_t)+3*TIME_WIDTH-1:0] q_data,
    output logic                                q_pop,
    input  logic [tte_pkg::DATA_W-1:0]          ticks_per_minute,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tte_pkg::out_item_t                  m_data
);

    localparam int TW       = TIME_WIDTH;
    localparam int CTL_W    = $bits(tte_pkg::cmd_ctl_t);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NIB      = (TW + 2 + 3) / 4;
    localparam int N3       = NIB * 4;
    localparam int CNT3_W   = (NIB > 1) ? $clog2(NIB) : 1;

    tte_pkg::back_state_e state_reg;
    tte_pkg::back_state_e state_next;

    // Per-channel tempo and average interval.
    logic [tte_pkg::DATA_W-1:0] bpm_mem_reg [CHANNELS];
    logic [TW-1:0]              avg_mem_reg [CHANNELS];

    tte_pkg::cmd_ctl_t  q_ctl;
    tte_pkg::cmd_ctl_t  ctl_reg;
    logic [TW-1:0]      q_a;
    logic [TW-1:0]      q_b;
    logic [TW-1:0]      q_c;
    logic [TW-1:0]      b_reg;
    logic [TW-1:0]      c_reg;
    logic [TW+2:0]      a5_reg;
    logic [TW+2:0]      c5_reg;
    logic [TW+2:0]      a4_reg;
    logic [TW:0]        ab_reg;
    logic [TW+1:0]      sum3;
    logic               tempo_ok;

    logic [N3-1:0]      num3_reg;
    logic [N3-1:0]      quo3_reg;
    logic [1:0]         rem3_reg;
    logic [CNT3_W-1:0]  cnt3_reg;
    logic [5:0]         val3;
    logic [11:0]        prod3;
    logic [3:0]         qd3;
    logic [5:0]         r3;
    logic [TW-1:0]      avg;

    logic [CH_IDX_W-1:0] q_idx;
    logic [CH_IDX_W-1:0] idx;

    logic                        div_start;
    logic                        div_done;
    logic [tte_pkg::DATA_W-1:0]  div_quo;

    logic               res_load;
    logic               mem_write;
    tte_pkg::out_item_t res_next;
    tte_pkg::out_item_t res_reg;

    // Unpack the command at the head of the queue.
    assign q_ctl = tte_pkg::cmd_ctl_t'(q_data[CTL_W+3*TW-1 -: CTL_W]);
    assign q_a   = q_data[3*TW-1 -: TW];
    assign q_b   = q_data[2*TW-1 -: TW];
    assign q_c   = q_data[TW-1:0];
    assign q_idx = CH_IDX_W'(q_ctl.channel);
    assign idx   = CH_IDX_W'(ctl_reg.channel);

    // Tempo window: 4b < 5a, 4c < 5a and 4a < 5c, exact.
    assign tempo_ok = ({1'b0, b_reg, 2'b00} < a5_reg)
                   && ({1'b0, c_reg, 2'b00} < a5_reg)
                   && (a4_reg < c5_reg);
    assign sum3     = {1'b0, ab_reg} + {2'b00, c_reg};

    // One nibble of the divide by three; quotient digit by reciprocal 43/128.
    assign val3  = {rem3_reg, num3_reg[N3-1 -: 4]};
    assign prod3 = {6'b0, val3} * 12'd43;
    assign qd3   = prod3[10:7];
    assign r3    = val3 - {1'b0, qd3, 1'b0} - {2'b00, qd3};
    assign avg   = quo3_reg[TW-1:0];

    tte_div #(
        .NUM_W (tte_pkg::DATA_W),
        .DEN_W (TW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (ticks_per_minute),
        .den     (avg),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tte_pkg::ST_IDLE: begin
                if (q_not_empty) begin
                    if (q_ctl.kind == tte_pkg::CMD_NEW) begin
                        state_next = tte_pkg::ST_CHECK;
                    end else begin
                        state_next = tte_pkg::ST_RESULT;
                    end
                end
            end
            tte_pkg::ST_CHECK: begin
                state_next = tempo_ok ? tte_pkg::ST_DIV3 : tte_pkg::ST_RESULT;
            end
            tte_pkg::ST_DIV3: begin
                if (cnt3_reg == CNT3_W'(NIB - 1)) begin
                    state_next = tte_pkg::ST_AVG;
                end
            end
            tte_pkg::ST_AVG: begin
                state_next = (avg == '0) ? tte_pkg::ST_RESULT : tte_pkg::ST_DIVIDE;
            end
            tte_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    state_next = tte_pkg::ST_RESULT;
                end
            end
            tte_pkg::ST_RESULT: begin
                if (m_ready) begin
                    state_next = tte_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tte_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer and the result to be registered.
    always_comb begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        res_load  = 1'b0;
        mem_write = 1'b0;
        res_next  = '0;
        case (state_reg)
            tte_pkg::ST_IDLE: begin
                q_pop = q_not_empty;
                if (q_not_empty) begin
                    case (q_ctl.kind)
                        tte_pkg::CMD_NEW: begin
                            res_load = 1'b0;
                        end
                        tte_pkg::CMD_REPEAT: begin
                            res_load               = 1'b1;
                            res_next.bpm           = bpm_mem_reg[q_idx];
                            res_next.beat_interval = tte_pkg::DATA_W'(avg_mem_reg[q_idx]);
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            tte_pkg::ST_CHECK: begin
                if (!tempo_ok) begin
                    res_load               = 1'b1;
                    res_next.bpm           = bpm_mem_reg[idx];
                    res_next.beat_interval = tte_pkg::DATA_W'(avg_mem_reg[idx]);
                end
            end
            tte_pkg::ST_AVG: begin
                if (avg == '0) begin
                    res_load               = 1'b1;
                    res_next.bpm           = bpm_mem_reg[idx];
                    res_next.beat_interval = tte_pkg::DATA_W'(avg_mem_reg[idx]);
                end else begin
                    div_start = 1'b1;
                end
            end
            tte_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    res_load               = 1'b1;
                    mem_write              = 1'b1;
                    res_next.updated       = 1'b1;
                    res_next.bpm           = div_quo;
                    res_next.beat_interval = tte_pkg::DATA_W'(avg);
                end
            end
            default: begin
                res_load = 1'b0;
            end
        endcase
    end

    assign m_valid = (state_reg == tte_pkg::ST_RESULT);
    assign m_data  = res_reg;

    // Sequencer state and per-channel tempo storage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tte_pkg::ST_IDLE;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                bpm_mem_reg[ch] <= '0;
                avg_mem_reg[ch] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (mem_write) begin
                bpm_mem_reg[idx] <= div_quo;
                avg_mem_reg[idx] <= avg;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ctl_reg <= q_ctl;
            b_reg   <= q_b;
            c_reg   <= q_c;
            a5_reg  <= {3'b000, q_a} + {1'b0, q_a, 2'b00};
            c5_reg  <= {3'b000, q_c} + {1'b0, q_c, 2'b00};
            a4_reg  <= {1'b0, q_a, 2'b00};
            ab_reg  <= {1'b0, q_a} + {1'b0, q_b};
        end
        if (state_reg == tte_pkg::ST_CHECK) begin
            num3_reg <= N3'(sum3);
            quo3_reg <= '0;
            rem3_reg <= '0;
            cnt3_reg <= '0;
        end else if (state_reg == tte_pkg::ST_DIV3) begin
            num3_reg <= {num3_reg[N3-5:0], 4'b0000};
            quo3_reg <= {quo3_reg[N3-5:0], qd3};
            rem3_reg <= r3[1:0];
            cnt3_reg <= cnt3_reg + 1'b1;
        end
        if (res_load) begin
            res_reg <= res_next;
        end
    end

endmodule

>>> rtl/tap_tempo_bpm_estimator.sv
// Top level of the tap tempo BPM estimator.
//
//  Channel   Ports                          Carries
//  input     s_valid, s_ready, s_data       channel number and tick stamp
//  result    m_valid, m_ready, m_data       updated flag, bpm, beat interval
//  config    cfg_valid, cfg_ready, cfg_data ticks per minute, always ready
//
// A new stamp that passes the tempo window goes through the tempo check, the divide by
// three one nibble at a time and the BPM divider, which gives one quotient bit per cycle.
// Repeats, unknown channels and rejected tempos skip both divisions. A two-entry queue
// lets the front take requests while the back waits on m_ready. Reset is synchronous
// and clears history and tempo storage.
module tap_tempo_bpm_estimator #(
    parameter int CHANNELS   = 2,
    parameter int TIME_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  tte_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output tte_pkg::out_item_t         m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tte_pkg::DATA_W-1:0] cfg_data
);

    localparam int CMD_W = $bits(tte_pkg::cmd_ctl_t) + 3 * TIME_WIDTH;

    logic [tte_pkg::DATA_W-1:0] tpm_reg;
    logic                       q_push;
    logic                       q_full;
    logic                       q_pop;
    logic                       q_not_empty;
    logic [CMD_W-1:0]           q_push_data;
    logic [CMD_W-1:0]           q_pop_data;

    // Ticks-per-minute register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpm_reg <= tte_pkg::TPM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            tpm_reg <= cfg_data;
        end
    end

    tte_front #(
        .CHANNELS   (CHANNELS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_push_data)
    );

    tte_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty)
    );

    tte_back #(
        .CHANNELS   (CHANNELS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_not_empty      (q_not_empty),
        .q_data           (q_pop_data),
        .q_pop            (q_pop),
        .ticks_per_minute (tpm_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data)
    );

endmodule

>>> rtl/tte_checker.sv
// Port-level checker for the tap tempo BPM estimator and its binding.
module tte_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input tte_pkg::out_item_t m_data
);

    // Requests accepted whose results have not yet been taken.
    logic [2:0] pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            case ({s_valid && s_ready, m_valid && m_ready})
                2'b10:   pending_reg <= pending_reg + 1'b1;
                2'b01:   pending_reg <= pending_reg - 1'b1;
                default: pending_reg <= pending_reg;
            endcase
        end
    end

    // A stalled result holds its value.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Every result belongs to an accepted request.
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 3'd0)
        else $error("result without a pending request");

    // With the queue and the back part full, no request is taken.
    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg >= 3'd3 |-> !s_ready)
        else $error("more requests in flight than the design can hold");

    // Reset leaves no result on the port.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind tap_tempo_bpm_estimator tte_checker u_checker (.*);

>>> test/tap_tempo_bpm_estimator_tb.sv
// Self-checking testbench for the tap tempo BPM estimator with a cycle-free tempo predictor.
module tap_tempo_bpm_estimator_tb;

    localparam int CLK_HALF       = 5;
    localparam int SETTLE_CYCLES  = 64;     // a little above the slowest request latency
    localparam int WATCHDOG_LIMIT = 4000;   // cycles without any handshake
    localparam logic [tte_pkg::DATA_W-1:0] TPM_MAX = '1;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    tte_pkg::in_item_t          s_data    = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    tte_pkg::out_item_t         m_data;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [tte_pkg::DATA_W-1:0] cfg_data  = '0;

    // Predicted per-channel history and tempo.
    logic [tte_pkg::DATA_W-1:0] tap_ring [2][4];
    logic [1:0]                 ring_slot [2];
    logic [tte_pkg::DATA_W-1:0] last_stamp [2];
    logic [tte_pkg::DATA_W-1:0] tempo_now [2];
    logic [tte_pkg::DATA_W-1:0] interval_now [2];
    logic [tte_pkg::DATA_W-1:0] ticks_per_minute;

    tte_pkg::out_item_t pending_tempos[$];

    int  error_count   = 0;
    int  taps_sent     = 0;
    int  fresh_taps    = 0;
    int  results_seen  = 0;
    int  updates_seen  = 0;
    int  tpm_settings  = 1;
    int  rx_wait       = 0;
    bit  rx_steady     = 1'b0;
    bit  tx_steady     = 1'b0;
    int  idle_cycles   = 0;

    tap_tempo_bpm_estimator #(
        .CHANNELS  (2),
        .TIME_WIDTH(32)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Free-running clock.
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // True when 4*x < 5*y, computed without overflow.
    function automatic bit quarter_fits(input logic [tte_pkg::DATA_W-1:0] x,
                                        input logic [tte_pkg::DATA_W-1:0] y);
        return (35'(x) * 35'd4) < (35'(y) * 35'd5);
    endfunction

    // Applies one request to the predicted state and returns the result it should produce.
    function automatic tte_pkg::out_item_t predict_tempo(input tte_pkg::in_item_t req);
        tte_pkg::out_item_t           res;
        int                           ch;
        logic [1:0]                   w;
        logic [tte_pkg::DATA_W-1:0]   s0, s1, s2, s3, a, b, c, avg;
        logic [tte_pkg::DATA_W+1:0]   total;
        ch          = req.channel;
        res.updated = 1'b0;
        if (req.stamp != last_stamp[ch]) begin
            w               = ring_slot[ch];
            tap_ring[ch][w] = req.stamp;
            s0 = tap_ring[ch][w + 2'd1];
            s1 = tap_ring[ch][w + 2'd2];
            s2 = tap_ring[ch][w + 2'd3];
            s3 = tap_ring[ch][w];
            a  = s1 - s0;
            b  = s2 - s1;
            c  = s3 - s2;
            if (quarter_fits(b, a) && quarter_fits(c, a) && quarter_fits(a, c)) begin
                total = (tte_pkg::DATA_W+2)'(a) + (tte_pkg::DATA_W+2)'(b)
                      + (tte_pkg::DATA_W+2)'(c);
                avg   = tte_pkg::DATA_W'(total / 3);
                if (avg != '0) begin
                    interval_now[ch] = avg;
                    tempo_now[ch]    = ticks_per_minute / avg;
                    res.updated      = 1'b1;
                end
            end
            last_stamp[ch] = req.stamp;
            ring_slot[ch]  = w + 2'd1;
        end
        res.bpm           = tempo_now[ch];
        res.beat_interval = interval_now[ch];
        return res;
    endfunction

    // Sends one tap request after a random gap and records its predicted result.
    task automatic send_tap(input logic ch, input logic [tte_pkg::DATA_W-1:0] stamp);
        int                gap;
        tte_pkg::in_item_t req;
        req.channel = ch;
        req.stamp   = stamp;
        if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (stamp != last_stamp[ch]) fresh_taps++;
        taps_sent++;
        pending_tempos.push_back(predict_tempo(req));
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_tempos.size() != 0) @(posedge aclk);
    endtask

    // Writes the ticks-per-minute register once the block has gone idle.
    task automatic write_ticks_per_minute(input logic [tte_pkg::DATA_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        ticks_per_minute = value;
        tpm_settings++;
    endtask

    // Compares one returned result with the oldest prediction.
    task automatic compare_tempo_result(input tte_pkg::out_item_t got);
        tte_pkg::out_item_t want;
        results_seen++;
        if (got.updated) updates_seen++;
        if (pending_tempos.size() == 0) begin
            $error("result with no request outstanding: %p", got);
            error_count++;
        end else begin
            want = pending_tempos.pop_front();
            if (got.updated !== want.updated) begin
                $error("updated expected %0h actual %0h", want.updated, got.updated);
                error_count++;
            end
            if (got.bpm !== want.bpm) begin
                $error("bpm expected %0h actual %0h", want.bpm, got.bpm);
                error_count++;
            end
            if (got.beat_interval !== want.beat_interval) begin
                $error("beat_interval expected %0h actual %0h",
                       want.beat_interval, got.beat_interval);
                error_count++;
            end
        end
    endtask

    // Result side: check every accepted result and stall the receiver at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait  = 0;
        end else begin
            if (m_valid && m_ready) begin
                compare_tempo_result(m_data);
                if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
                rx_wait = rx_steady ? 0 : $urandom_range(0, 15);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_ready <= (rx_wait == 0);
        end
    end

    // Watchdog: the run is hung if no handshake happens for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog expired with %0d results outstanding", pending_tempos.size());
        $display("FAILURE");
        $finish;
    end

    // A zero stamp right after reset, and any stamp equal to the last one, is a repeat.
    task automatic test_repeat_after_reset();
        send_tap(1'b0, 32'd0);
        send_tap(1'b1, 32'd0);
    endtask

    // Even taps at 120 BPM lock on the third tap; a repeat keeps the tempo.
    task automatic test_steady_tempo();
        send_tap(1'b0, 32'd500000);
        send_tap(1'b0, 32'd1000000);
        send_tap(1'b0, 32'd1500000);
        send_tap(1'b0, 32'd2000000);
        send_tap(1'b0, 32'd2000000);
    endtask

    // A long last interval, then a long middle interval, both fall outside the window.
    task automatic test_rejected_tempo();
        send_tap(1'b0, 32'd4000000);
        send_tap(1'b0, 32'd4500000);
    endtask

    // Maximum intervals (stamps stepping back by one), then even taps across the wrap.
    // A zero average would need two equal stamps in a row on one channel, which the
    // repeat check never lets through, so that case cannot be provoked.
    task automatic test_wrap_and_extremes();
        send_tap(1'b1, 32'hFFFF_FFFF);
        send_tap(1'b1, 32'hFFFF_FFFE);
        send_tap(1'b1, 32'hFFFF_FFFD);
        send_tap(1'b1, 32'hFFFF_FFFC);
        send_tap(1'b1, 32'hFFFF_FF80);
        send_tap(1'b1, 32'h0000_0000);
        send_tap(1'b1, 32'h0000_0080);
        send_tap(1'b1, 32'h0000_0100);
    endtask

    // One-tick steps, then a one-tick average against the largest, smallest and zero
    // ticks per minute.
    task automatic test_tick_rate_extremes();
        send_tap(1'b0, 32'd10);
        send_tap(1'b0, 32'd11);
        send_tap(1'b0, 32'd12);
        write_ticks_per_minute(TPM_MAX);
        send_tap(1'b0, 32'd13);
        write_ticks_per_minute(32'd1);
        send_tap(1'b0, 32'd14);
        write_ticks_per_minute(32'd0);
        send_tap(1'b0, 32'd15);
        send_tap(1'b1, 32'h0000_0180);
    endtask

    // Mostly runs of jittered taps at random scales, mixed with noise and broken runs.
    task automatic test_random_taps(input int target);
        int                         start;
        int                         len;
        int                         width;
        logic                       ch;
        logic [tte_pkg::DATA_W-1:0] interval, spread, stamp;
        start = fresh_taps;
        while (fresh_taps - start < target) begin
            if ($urandom_range(0, 99) < 3) drain_results();
            if ($urandom_range(0, 9) < 7) begin
                ch       = $urandom_range(0, 1);
                width    = $urandom_range(1, 32);
                interval = ($urandom >> (32 - width)) | 32'd1;
                spread   = interval >> 3;
                stamp    = $urandom;
                len      = $urandom_range(3, 8);
                for (int k = 0; k < len; k++) begin
                    stamp = stamp + interval + ($urandom % (2 * spread + 1)) - spread;
                    if ($urandom_range(0, 19) == 0) stamp = stamp + interval;
                    send_tap(ch, stamp);
                    if ($urandom_range(0, 9) == 0) send_tap(ch, stamp);
                    if ($urandom_range(0, 9) == 0) send_tap(!ch, $urandom);
                end
            end else begin
                ch = $urandom_range(0, 1);
                if ($urandom_range(0, 3) == 0)
                    send_tap(ch, last_stamp[ch]);
                else
                    send_tap(ch, $urandom);
            end
        end
    endtask

    // Test sequence.
    initial begin
        for (int ch = 0; ch < 2; ch++) begin
            for (int i = 0; i < 4; i++) tap_ring[ch][i] = '0;
            ring_slot[ch]    = '0;
            last_stamp[ch]   = '0;
            tempo_now[ch]    = '0;
            interval_now[ch] = '0;
        end
        ticks_per_minute = tte_pkg::TPM_RESET;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_repeat_after_reset();
        test_steady_tempo();
        test_rejected_tempo();
        test_wrap_and_extremes();
        test_tick_rate_extremes();

        write_ticks_per_minute(tte_pkg::TPM_RESET);
        test_random_taps(150);
        write_ticks_per_minute($urandom | 32'd1);
        test_random_taps(150);
        write_ticks_per_minute(TPM_MAX);
        test_random_taps(150);
        write_ticks_per_minute($urandom_range(1, 1000));
        test_random_taps(150);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_tempos.size() != 0) begin
            $error("%0d results never arrived", pending_tempos.size());
            error_count++;
        end

        $display("Sent %0d tap requests (%0d new stamps) over %0d tick-rate settings;",
                 taps_sent, fresh_taps, tpm_settings);
        $display("checked %0d results, %0d of them tempo updates, %0d errors.",
                 results_seen, updates_seen, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
rtl/tte_pkg.sv
rtl/tte_queue.sv
rtl/tte_front.sv
rtl/tte_div.sv
rtl/tte_back.sv
rtl/tap_tempo_bpm_estimator.sv
rtl/tte_checker.sv
test/tap_tempo_bpm_estimator_tb.sv
